// ----- rtl/core/efc_pkg.sv -----
// shared types, constants and crc helper for the encoder frame checker
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;

  localparam logic [7:0]  CrcPoly  = 8'h07;
  localparam logic [16:0] RateOne  = 17'd65536;
  localparam logic [8:0]  DegScale = 9'd360;
  localparam int          DegShift = 5;

  // one received frame
  typedef struct packed {
    logic [7:0]  angle_high;
    logic [7:0]  angle_mid;
    logic [7:0]  angle_low_status;
    logic [7:0]  crc_byte;
    logic [16:0] time_step;
  } efc_in_t;

  // one checked frame with tracker state after it
  typedef struct packed {
    logic        frame_ok;
    logic [2:0]  status_bits;
    logic [20:0] angle_code;
    logic [24:0] angle_degrees;
    logic [31:0] error_count;
    logic [16:0] error_rate;
  } efc_out_t;

  // decoded frame fields handed from the crc check to the tracker
  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [20:0] angle;
  } efc_chk_t;

  // one byte through the crc-8 register, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int j = 0; j < 8; j++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/efc_crc8.sv -----
// crc-8 check and field decode of one frame
`timescale 1ns / 1ps
`default_nettype none
module efc_crc8 (
  input  wire efc_pkg::efc_in_t  item,
  output efc_pkg::efc_chk_t      chk
);
  import efc_pkg::*;

  logic [7:0] crc_a;
  logic [7:0] crc_b;
  logic [7:0] crc_c;

  // three chained byte steps from a zero start value
  always_comb begin
    crc_a = crc8_byte(item.angle_high);
    crc_b = crc8_byte(crc_a ^ item.angle_mid);
    crc_c = crc8_byte(crc_b ^ item.angle_low_status);
  end

  // angle and status fields, good-frame decision
  always_comb begin
    chk.status = item.angle_low_status[2:0];
    chk.angle  = {item.angle_high, item.angle_mid, item.angle_low_status[7:3]};
    chk.ok     = (crc_c == item.crc_byte) && (item.angle_low_status[2:0] == 3'd0);
  end

endmodule
`default_nettype wire

// ----- rtl/core/efc_track.sv -----
// held angle, error counter and filtered error rate
`timescale 1ns / 1ps
`default_nettype none
module efc_track (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    adv,
  input  wire efc_pkg::efc_in_t  item,
  output efc_pkg::efc_out_t      res
);
  import efc_pkg::*;

  efc_chk_t    chk;
  logic [20:0] angle_r,  angle_nxt;
  logic [24:0] deg_r,    deg_nxt;
  logic [31:0] cnt_r,    cnt_nxt;
  logic [16:0] rate_r,   rate_nxt;
  logic [16:0] dt_sat;
  logic [16:0] rate_cl;
  logic [16:0] mul_b;
  logic [33:0] prod;
  logic [29:0] deg_prod;

  efc_crc8 u_crc (
    .item (item),
    .chk  (chk)
  );

  // saturate time step and rate at one
  always_comb begin
    dt_sat  = (item.time_step > RateOne) ? RateOne : item.time_step;
    rate_cl = (rate_r > RateOne) ? RateOne : rate_r;
  end

  // one shared filter multiply: toward one on a bad frame, toward zero on a good one
  always_comb begin
    mul_b    = chk.ok ? rate_cl : (RateOne - rate_cl);
    prod     = {17'd0, dt_sat} * {17'd0, mul_b};
    deg_prod = {9'd0, chk.angle} * {21'd0, DegScale};
  end

  // next state
  always_comb begin
    angle_nxt = angle_r;
    deg_nxt   = deg_r;
    cnt_nxt   = cnt_r;
    if (chk.ok) begin
      angle_nxt = chk.angle;
      deg_nxt   = deg_prod[DegShift +: 25];
      rate_nxt  = rate_cl - prod[32:16];
    end else begin
      cnt_nxt  = cnt_r + 32'd1;
      rate_nxt = rate_cl + prod[32:16];
    end
  end

  // state registers, updated as each item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      deg_r   <= '0;
      cnt_r   <= '0;
      rate_r  <= '0;
    end else if (adv) begin
      angle_r <= angle_nxt;
      deg_r   <= deg_nxt;
      cnt_r   <= cnt_nxt;
      rate_r  <= rate_nxt;
    end
  end

  // result fields for this item
  always_comb begin
    res.frame_ok      = chk.ok;
    res.status_bits   = chk.status;
    res.angle_code    = angle_nxt;
    res.angle_degrees = deg_nxt;
    res.error_count   = cnt_nxt;
    res.error_rate    = rate_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/encoder_frame_crc_check_core.sv -----
// top level of the encoder frame crc checker
`timescale 1ns / 1ps
`default_nettype none
// Checks one angle-sensor frame per item: crc-8 (poly 0x07, init 0, msb first)
// over the three data bytes plus a zero-status test. A good frame updates the
// held 21-bit angle and its Q9.16 degree value; a bad frame bumps a wrapping
// 32-bit error counter; every frame moves a Q1.16 error rate toward 1.0 or 0.0
// by the time step (saturated at 1.0). Each item is held in the input register,
// then its result in the result register. One item per cycle is sustained
// while out_ready is high; the crc, the 17x17 filter multiply and the 21x9
// degree multiply all sit in the single stage between the two registers, and
// the tracker state feeds back within that stage.
module encoder_frame_crc_check_core (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire efc_pkg::efc_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output efc_pkg::efc_out_t      out_data
);
  import efc_pkg::*;

  logic     s1_valid_r;
  efc_in_t  s1_item_r;
  logic     out_valid_r;
  efc_out_t out_data_r;
  efc_out_t res;
  logic     adv;

  // item moves on when the result register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  efc_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.error_rate <= RateOne)
    else $error("error rate above one");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_ok |-> out_data.status_bits == 3'd0)
    else $error("good frame with nonzero status");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !res.frame_ok |=> out_data.error_count == $past(res.error_count))
    else $error("error count not carried to result");

  a_deg_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.angle_degrees ==
      25'(({9'd0, out_data.angle_code} * 30'd360) >> DegShift))
    else $error("degrees do not match held angle");

endmodule
`default_nettype wire

// ----- tb/encoder_frame_crc_check_core_test.sv -----
// testbench for the encoder frame crc checker: queued driver, checking monitor, watchdog
`timescale 1ns / 1ps
module encoder_frame_crc_check_core_test;
  import efc_pkg::*;

  localparam int RandFrames  = 1150;
  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 400;
  localparam int HoldAtCount = 900;
  localparam int DrainCycles = 10;

  // idling phases
  typedef enum logic [1:0] {
    PhSlowRx,
    PhSlowTx,
    PhNoIdle
  } idle_phase_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  efc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  efc_out_t out_data;

  efc_in_t     frames_pending[$];
  efc_out_t    checks_due[$];
  idle_phase_t phase = PhSlowRx;
  int          frames_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;

  // tracker copy: held angle, degrees, bad-frame count, filtered rate
  logic [20:0] trk_angle = '0;
  logic [24:0] trk_degrees = '0;
  logic [31:0] trk_bad = '0;
  logic [16:0] trk_rate = '0;

  encoder_frame_crc_check_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // crc-8, poly 0x07, init 0, msb first, over three data bytes
  function automatic logic [7:0] frame_crc(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    logic [7:0]  c;
    logic [23:0] stream;
    c = 8'h00;
    stream = {b0, b1, b2};
    for (int i = 23; i >= 0; i--) begin
      if (c[7] ^ stream[i]) begin
        c = {c[6:0], 1'b0} ^ 8'h07;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // advance the tracker by one frame and return the expected result
  function automatic efc_out_t track_frame(efc_in_t f);
    efc_out_t    r;
    logic        good;
    logic [16:0] step;
    logic [33:0] prod;
    logic [29:0] deg_full;
    step = (f.time_step > 17'd65536) ? 17'd65536 : f.time_step;
    good = (frame_crc(f.angle_high, f.angle_mid, f.angle_low_status) == f.crc_byte) &&
           (f.angle_low_status[2:0] == 3'd0);
    if (good) begin
      trk_angle = {f.angle_high, f.angle_mid, f.angle_low_status[7:3]};
      deg_full = 30'(trk_angle) * 30'd360;
      trk_degrees = deg_full[29:5];
      prod = 34'(step) * 34'(trk_rate);
      trk_rate = trk_rate - 17'(prod >> 16);
    end else begin
      trk_bad = trk_bad + 32'd1;
      prod = 34'(step) * 34'(17'd65536 - trk_rate);
      trk_rate = trk_rate + 17'(prod >> 16);
    end
    r.frame_ok      = good;
    r.status_bits   = f.angle_low_status[2:0];
    r.angle_code    = trk_angle;
    r.angle_degrees = trk_degrees;
    r.error_count   = trk_bad;
    r.error_rate    = trk_rate;
    return r;
  endfunction

  function automatic efc_in_t pack_frame(logic [7:0] hi, logic [7:0] mid, logic [7:0] lo,
                                         logic [7:0] crc, logic [16:0] dt);
    efc_in_t f;
    f.angle_high       = hi;
    f.angle_mid        = mid;
    f.angle_low_status = lo;
    f.crc_byte         = crc;
    f.time_step        = dt;
    return f;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // driver: offer the next frame, predict on acceptance
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (phase == PhSlowRx) ? 24 : (phase == PhSlowTx) ? 67 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        checks_due.push_back(track_frame(in_data));
        frames_sent <= frames_sent + 1;
        phase <= (frames_sent + 1 < 400) ? PhSlowRx :
                 (frames_sent + 1 < 800) ? PhSlowTx : PhNoIdle;
      end
      if (!in_valid || in_ready) begin
        if (frames_pending.size() != 0 && !roll(idle_pct)) begin
          in_valid <= 1'b1;
          in_data  <= frames_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    efc_out_t want;
    int       idle_pct;
    idle_pct = (phase == PhSlowRx) ? 67 : (phase == PhSlowTx) ? 24 : 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (checks_due.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = checks_due.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected ok=%0d st=%0d ang=%0d deg=%0d cnt=%0d rate=%0d",
                     $time, want.frame_ok, want.status_bits, want.angle_code,
                     want.angle_degrees, want.error_count, want.error_rate);
            $display("%0t:          actual ok=%0d st=%0d ang=%0d deg=%0d cnt=%0d rate=%0d",
                     $time, out_data.frame_ok, out_data.status_bits, out_data.angle_code,
                     out_data.angle_degrees, out_data.error_count, out_data.error_rate);
            mismatches <= mismatches + 1;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_seen >= HoldAtCount) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !roll(idle_pct);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0]  hi;
    logic [7:0]  mid;
    logic [7:0]  lo;
    logic [7:0]  crc;
    logic [16:0] dt;
    int          kind;
    int          pick;

    // directed: extremes, good and bad frames, time step saturation
    frames_pending.push_back(pack_frame(8'h00, 8'h00, 8'h00, frame_crc(8'h00, 8'h00, 8'h00),
                                        17'd0));
    frames_pending.push_back(pack_frame(8'hFF, 8'hFF, 8'hF8, frame_crc(8'hFF, 8'hFF, 8'hF8),
                                        17'd65536));
    frames_pending.push_back(pack_frame(8'hFF, 8'hFF, 8'hFF, frame_crc(8'hFF, 8'hFF, 8'hFF),
                                        17'd65536));
    frames_pending.push_back(pack_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 17'd131071));
    frames_pending.push_back(pack_frame(8'h12, 8'h34, 8'h50, 8'hFF, 17'd65537));
    frames_pending.push_back(pack_frame(8'hA5, 8'h5A, 8'h01, frame_crc(8'hA5, 8'h5A, 8'h01),
                                        17'd32768));
    frames_pending.push_back(pack_frame(8'hA5, 8'h5A, 8'h02, frame_crc(8'hA5, 8'h5A, 8'h02),
                                        17'd1));
    frames_pending.push_back(pack_frame(8'hA5, 8'h5A, 8'h04, frame_crc(8'hA5, 8'h5A, 8'h04),
                                        17'd65535));
    frames_pending.push_back(pack_frame(8'h80, 8'h00, 8'h08, frame_crc(8'h80, 8'h00, 8'h08),
                                        17'd65536));
    frames_pending.push_back(pack_frame(8'h00, 8'h00, 8'h08, frame_crc(8'h00, 8'h00, 8'h08),
                                        17'd100000));
    frames_pending.push_back(pack_frame(8'h00, 8'h01, 8'h00, frame_crc(8'h00, 8'h01, 8'h00),
                                        17'd0));
    frames_pending.push_back(pack_frame(8'h7F, 8'hFF, 8'hF8,
                                        frame_crc(8'h7F, 8'hFF, 8'hF8) ^ 8'h01, 17'd65536));
    frames_pending.push_back(pack_frame(8'h7F, 8'hFF, 8'hF8,
                                        frame_crc(8'h7F, 8'hFF, 8'hF8) ^ 8'h80, 17'd0));
    frames_pending.push_back(pack_frame(8'h55, 8'hAA, 8'h57, 8'h00, 17'd43690));
    frames_pending.push_back(pack_frame(8'hAA, 8'h55, 8'hA8, frame_crc(8'hAA, 8'h55, 8'hA8),
                                        17'd21845));
    frames_pending.push_back(pack_frame(8'h00, 8'h00, 8'h00, frame_crc(8'h00, 8'h00, 8'h00),
                                        17'd65536));

    // random: mostly well-formed frames, some bad status, some corrupt crc
    for (int n = 0; n < RandFrames; n++) begin
      hi  = 8'($urandom_range(255));
      mid = 8'($urandom_range(255));
      lo  = 8'($urandom_range(255));
      kind = $urandom_range(99);
      if (kind < 60) begin
        lo[2:0] = 3'd0;
        crc = frame_crc(hi, mid, lo);
      end else if (kind < 75) begin
        lo[2:0] = 3'($urandom_range(7, 1));
        crc = frame_crc(hi, mid, lo);
      end else if (kind < 88) begin
        lo[2:0] = 3'd0;
        crc = frame_crc(hi, mid, lo) ^ 8'($urandom_range(255, 1));
      end else begin
        crc = 8'($urandom_range(255));
      end
      pick = $urandom_range(9);
      case (pick)
        0: dt = 17'd0;
        1: dt = 17'd65536;
        2: dt = 17'($urandom_range(131071, 65537));
        3: dt = 17'($urandom_range(255));
        4: dt = 17'($urandom_range(131071));
        default: dt = 17'($urandom_range(65535));
      endcase
      frames_pending.push_back(pack_frame(hi, mid, lo, crc, dt));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every frame to go in and every result to come out
    while (frames_pending.size() != 0 || in_valid) @(negedge clk);
    while (checks_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
